>>> design/wsm_pkg.sv
// shared types, constants and the quarter-wave sine builder for the window spectrum block
// no dependencies
package wsm_pkg;

    localparam int DEF_MAX_WINDOW      = 4096;
    localparam int DEF_TRIG_TABLE_BITS = 10;
    localparam int DEF_COEF_FRAC_BITS  = 16;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int FIDX_W    = 16;
    localparam int AMP_W     = 28;
    localparam int TRIG_W    = 17;

    localparam logic [AMP_W-1:0] AMP_MAX     = 28'hFFF_FFFF;
    localparam logic [63:0]      HALF_PI_Q30 = 64'd1686629713;
    localparam int               ROOT_STEPS  = 32;
    localparam int               SQ_STEPS    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TYPE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HANN_PHASE_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_START      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_LENGTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RECIP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_PHASE_STEP = 3'd6;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_MAG,
        ST_SQUARE,
        ST_SQWAIT,
        ST_ROOT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       fill;
        logic       start;
        logic       issue;
        logic       mag;
        logic       sq_go;
        logic [1:0] sq_sel;
        logic       root_go;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic fill_done;
        logic points_done;
        logic pipe_busy;
    } status_t;

    // sin(pi/2 * k / 2^tbits) in q1.16 from a nine-term taylor series in q30
    function automatic logic [TRIG_W-1:0] rom_entry(input int unsigned k,
                                                    input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        int unsigned i;
        x    = (64'(k) * HALF_PI_Q30) >> tbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (i = 1; i <= 8; i++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
            if (i[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        sum = (sum + 8192) >>> 14;
        if (sum > 65536)
            sum = 65536;
        return TRIG_W'(sum);
    endfunction

endpackage

>>> design/wsm_in_if.sv
// input channel of the window spectrum block: frequency index and sweep start flag
// uses wsm_pkg
interface wsm_in_if;
    logic                        valid;
    logic                        ready;
    logic [wsm_pkg::FIDX_W-1:0]  freq_index;
    logic                        first_of_sweep;

    modport source (output valid, output freq_index, output first_of_sweep, input ready);
    modport sink (input valid, input freq_index, input first_of_sweep, output ready);
endinterface

>>> design/wsm_out_if.sv
// result channel of the window spectrum block: index echo, magnitude and running peak
// uses wsm_pkg
interface wsm_out_if;
    logic                        valid;
    logic                        ready;
    logic [wsm_pkg::FIDX_W-1:0]  freq_index_out;
    logic [wsm_pkg::AMP_W-1:0]   amplitude;
    logic [wsm_pkg::AMP_W-1:0]   peak_amplitude;

    modport source (output valid, output freq_index_out, output amplitude,
                    output peak_amplitude, input ready);
    modport sink (input valid, input freq_index_out, input amplitude,
                  input peak_amplitude, output ready);
endinterface

>>> design/wsm_ram.sv
// generic ram: one write port, two read ports with registered read data
// no dependencies
module wsm_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> design/wsm_ctrl.sv
// controller of the window spectrum block: sequences fill, point sweep, square and root
// uses wsm_pkg
module wsm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             out_ready,
    output logic             out_valid,
    output wsm_pkg::cmd_t    cmd,
    input  wsm_pkg::status_t status
);

    wsm_pkg::state_t state_reg;
    wsm_pkg::state_t state_next;
    logic [4:0]      cnt_reg;
    logic [4:0]      cnt_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            can_finish;

    assign can_finish = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            wsm_pkg::ST_FILL:
                if (status.fill_done)
                    state_next = wsm_pkg::ST_IDLE;
            wsm_pkg::ST_IDLE:
                if (in_valid)
                    state_next = wsm_pkg::ST_RUN;
            wsm_pkg::ST_RUN:
                if (status.points_done)
                    state_next = wsm_pkg::ST_DRAIN;
            wsm_pkg::ST_DRAIN:
                if (!status.pipe_busy)
                    state_next = wsm_pkg::ST_MAG;
            wsm_pkg::ST_MAG:
            begin
                state_next = wsm_pkg::ST_SQUARE;
                cnt_next   = '0;
            end
            wsm_pkg::ST_SQUARE:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(wsm_pkg::SQ_STEPS - 1))
                    state_next = wsm_pkg::ST_SQWAIT;
            end
            wsm_pkg::ST_SQWAIT:
            begin
                state_next = wsm_pkg::ST_ROOT;
                cnt_next   = '0;
            end
            wsm_pkg::ST_ROOT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(wsm_pkg::ROOT_STEPS - 1))
                    state_next = wsm_pkg::ST_DONE;
            end
            wsm_pkg::ST_DONE:
                if (can_finish)
                    state_next = wsm_pkg::ST_IDLE;
            default:
                state_next = wsm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            wsm_pkg::ST_FILL:
                cmd.fill = 1'b1;
            wsm_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            wsm_pkg::ST_RUN:
                cmd.issue = !status.points_done;
            wsm_pkg::ST_MAG:
                cmd.mag = 1'b1;
            wsm_pkg::ST_SQUARE:
            begin
                cmd.sq_go  = 1'b1;
                cmd.sq_sel = cnt_reg[1:0];
            end
            wsm_pkg::ST_ROOT:
                cmd.root_go = 1'b1;
            wsm_pkg::ST_DONE:
                if (can_finish)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                end
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wsm_pkg::ST_FILL;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> design/wsm_datapath.sv
// datapath of the window spectrum block: config registers, trig rams, point pipeline,
// accumulators, squaring and bit-serial square root; uses wsm_pkg and wsm_ram
module wsm_datapath #(
    parameter int MAX_WINDOW      = wsm_pkg::DEF_MAX_WINDOW,
    parameter int TRIG_TABLE_BITS = wsm_pkg::DEF_TRIG_TABLE_BITS,
    parameter int COEF_FRAC_BITS  = wsm_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [wsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wsm_pkg::CFG_W-1:0]       cfg_data,
    input  wsm_pkg::cmd_t                   cmd,
    output wsm_pkg::status_t                status,
    input  logic [wsm_pkg::FIDX_W-1:0]      in_freq_index,
    input  logic                            in_first,
    output logic [wsm_pkg::FIDX_W-1:0]      freq_index_out,
    output logic [wsm_pkg::AMP_W-1:0]       amplitude,
    output logic [wsm_pkg::AMP_W-1:0]       peak_amplitude
);

    localparam int TB    = TRIG_TABLE_BITS;
    localparam int CF    = COEF_FRAC_BITS;
    localparam int QN    = 1 << TB;
    localparam int DEPTH = QN + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int FCW   = TB + 2;
    localparam int LW    = $clog2(MAX_WINDOW + 1);
    localparam int TW    = wsm_pkg::TRIG_W;
    localparam int PW    = CF + 20;
    localparam int ACC_W = CF + 20 + $clog2(MAX_WINDOW);

    // configuration registers
    logic        window_type_reg;
    logic [12:0] window_length_reg;
    logic [31:0] hann_phase_step_reg;
    logic [12:0] ramp_start_reg;
    logic [12:0] ramp_length_reg;
    logic [16:0] ramp_recip_reg;
    logic [31:0] freq_phase_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_type_reg     <= 1'b1;
            window_length_reg   <= 13'd1024;
            hann_phase_step_reg <= 32'd4194304;
            ramp_start_reg      <= '0;
            ramp_length_reg     <= '0;
            ramp_recip_reg      <= '0;
            freq_phase_step_reg <= 32'd1048576;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wsm_pkg::CFG_WINDOW_TYPE:     window_type_reg     <= cfg_data[0];
                wsm_pkg::CFG_WINDOW_LENGTH:   window_length_reg   <= cfg_data[12:0];
                wsm_pkg::CFG_HANN_PHASE_STEP: hann_phase_step_reg <= cfg_data;
                wsm_pkg::CFG_RAMP_START:      ramp_start_reg      <= cfg_data[12:0];
                wsm_pkg::CFG_RAMP_LENGTH:     ramp_length_reg     <= cfg_data[12:0];
                wsm_pkg::CFG_RAMP_RECIP:      ramp_recip_reg      <= cfg_data[16:0];
                wsm_pkg::CFG_FREQ_PHASE_STEP: freq_phase_step_reg <= cfg_data;
                default:                      window_type_reg     <= window_type_reg;
            endcase
        end
    end

    // quarter-wave table fill after reset
    logic [TW-1:0]  rom_const [DEPTH];
    logic [FCW-1:0] fill_cnt_reg;
    logic           rom_we;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_rom
        assign rom_const[g] = wsm_pkg::rom_entry(g, TB);
    end

    assign status.fill_done = (fill_cnt_reg == FCW'(DEPTH));
    assign rom_we           = cmd.fill && !status.fill_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_cnt_reg <= '0;
        else if (rom_we)
            fill_cnt_reg <= fill_cnt_reg + FCW'(1);
    end

    // phase to {negate, table address}
    function automatic logic [AW:0] trig_addr(input logic [31:0] ph);
        logic [31:0]   r;
        logic [TB+1:0] k;
        logic [AW-1:0] idx;
        r   = ph + (32'd1 << (29 - TB));
        k   = r[31:30-TB];
        idx = {1'b0, k[TB-1:0]};
        if (k[TB])
            idx = AW'(QN) - idx;
        return {k[TB+1], idx};
    endfunction

    // point sequencing
    localparam int FIDX_W_L = wsm_pkg::FIDX_W;
    logic [FIDX_W_L-1:0] fidx_reg;
    logic          first_reg;
    logic [31:0]   fstep_reg;
    logic [31:0]   fph_reg;
    logic [31:0]   hph_reg;
    logic [LW-1:0] n_reg;
    logic [16:0]   len17;
    logic [LW-1:0] len_eff;

    assign len17   = (17'(window_length_reg) > 17'(MAX_WINDOW)) ? 17'(MAX_WINDOW)
                                                                 : 17'(window_length_reg);
    assign len_eff = LW'(len17);
    assign status.points_done = (n_reg == len_eff);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            fidx_reg  <= in_freq_index;
            first_reg <= in_first;
            fstep_reg <= freq_phase_step_reg * 32'(in_freq_index);
            fph_reg   <= '0;
            hph_reg   <= '0;
            n_reg     <= '0;
        end
        else if (cmd.issue)
        begin
            fph_reg <= fph_reg + fstep_reg;
            hph_reg <= hph_reg + hann_phase_step_reg;
            n_reg   <= n_reg + LW'(1);
        end
    end

    // stage 0: table addresses and ramp product
    logic [AW:0]   fc_addr;
    logic [AW:0]   fs_addr;
    logic [AW:0]   hc_addr;
    logic [17:0]   n18;
    logic [17:0]   rs18;
    logic [17:0]   end18;
    logic [12:0]   rdiff;
    logic [29:0]   rprod;
    logic [TW-1:0] cos_f_raw;
    logic [TW-1:0] sin_f_raw;
    logic [TW-1:0] cos_h_raw;

    assign fc_addr = trig_addr(fph_reg + 32'h4000_0000);
    assign fs_addr = trig_addr(fph_reg);
    assign hc_addr = trig_addr(hph_reg + 32'h4000_0000);
    assign n18     = 18'(n_reg);
    assign rs18    = 18'(ramp_start_reg);
    assign end18   = rs18 + 18'(ramp_length_reg);
    assign rdiff   = 13'(n18 - rs18);
    assign rprod   = 30'(rdiff) * 30'(ramp_recip_reg);

    wsm_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_ram_freq (
        .clk     (clk),
        .we      (rom_we),
        .waddr   (fill_cnt_reg[AW-1:0]),
        .wdata   (rom_const[fill_cnt_reg[AW-1:0]]),
        .raddr_a (fc_addr[AW-1:0]),
        .raddr_b (fs_addr[AW-1:0]),
        .rdata_a (cos_f_raw),
        .rdata_b (sin_f_raw)
    );

    wsm_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_ram_hann (
        .clk     (clk),
        .we      (rom_we),
        .waddr   (fill_cnt_reg[AW-1:0]),
        .wdata   (rom_const[fill_cnt_reg[AW-1:0]]),
        .raddr_a (hc_addr[AW-1:0]),
        .raddr_b (hc_addr[AW-1:0]),
        .rdata_a (cos_h_raw),
        .rdata_b ()
    );

    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        v4_reg;
    logic        neg_fc_s1;
    logic        neg_fs_s1;
    logic        neg_hc_s1;
    logic        below_s1;
    logic        above_s1;
    logic [29:0] rprod_s1;

    always_ff @(posedge clk)
    begin
        neg_fc_s1 <= fc_addr[AW];
        neg_fs_s1 <= fs_addr[AW];
        neg_hc_s1 <= hc_addr[AW];
        below_s1  <= n18 < rs18;
        above_s1  <= n18 >= end18;
        rprod_s1  <= rprod;
    end

    // stage 1: signed trig values, window and ramp
    logic signed [TW:0]   cos_f;
    logic signed [TW:0]   sin_f;
    logic signed [TW:0]   cos_h;
    logic signed [TW+1:0] hsum;
    logic [16:0]          w16;
    logic [CF+16:0]       wwide;
    logic [16:0]          ramp_s1;

    assign cos_f = neg_fc_s1 ? -$signed({1'b0, cos_f_raw}) : $signed({1'b0, cos_f_raw});
    assign sin_f = neg_fs_s1 ? -$signed({1'b0, sin_f_raw}) : $signed({1'b0, sin_f_raw});
    assign cos_h = neg_hc_s1 ? -$signed({1'b0, cos_h_raw}) : $signed({1'b0, cos_h_raw});
    assign hsum  = (TW+2)'(65536) - (TW+2)'(cos_h);
    assign w16   = window_type_reg ? hsum[17:1] : 17'd65536;
    assign wwide = (CF+17)'(w16) << CF;

    always_comb
    begin
        if (below_s1)
            ramp_s1 = '0;
        else if (above_s1 || rprod_s1 > 30'd65536)
            ramp_s1 = 17'd65536;
        else
            ramp_s1 = rprod_s1[16:0];
    end

    logic [CF:0]          wc_s2;
    logic [16:0]          ramp_s2;
    logic signed [TW:0]   cos_s2;
    logic signed [TW:0]   sin_s2;

    always_ff @(posedge clk)
    begin
        wc_s2   <= (CF+1)'(wwide >> 16);
        ramp_s2 <= ramp_s1;
        cos_s2  <= cos_f;
        sin_s2  <= sin_f;
    end

    // stage 2: coefficient
    logic [CF+17:0]     cprod;
    logic [CF:0]        coef_s3;
    logic signed [TW:0] cos_s3;
    logic signed [TW:0] sin_s3;

    assign cprod = (CF+18)'(wc_s2) * (CF+18)'(ramp_s2);

    always_ff @(posedge clk)
    begin
        coef_s3 <= (CF+1)'(cprod >> 16);
        cos_s3  <= cos_s2;
        sin_s3  <= sin_s2;
    end

    // stage 3: products
    logic signed [PW-1:0] pre_s4;
    logic signed [PW-1:0] pim_s4;

    always_ff @(posedge clk)
    begin
        pre_s4 <= PW'($signed({1'b0, coef_s3})) * PW'(cos_s3);
        pim_s4 <= PW'($signed({1'b0, coef_s3})) * PW'(sin_s3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign status.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;

    // stage 4: accumulation
    logic signed [ACC_W-1:0] acc_re_reg;
    logic signed [ACC_W-1:0] acc_im_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v4_reg)
        begin
            acc_re_reg <= acc_re_reg + {{(ACC_W-PW){pre_s4[PW-1]}}, pre_s4};
            acc_im_reg <= acc_im_reg + {{(ACC_W-PW){pim_s4[PW-1]}}, pim_s4};
        end
    end

    // magnitudes rounded to q16
    logic [ACC_W-1:0] abs_re;
    logic [ACC_W-1:0] abs_im;
    logic [ACC_W:0]   rnd_re;
    logic [ACC_W:0]   rnd_im;
    logic [63:0]      a_reg;
    logic [63:0]      b_reg;

    assign abs_re = acc_re_reg[ACC_W-1] ? ACC_W'(-acc_re_reg) : ACC_W'(acc_re_reg);
    assign abs_im = acc_im_reg[ACC_W-1] ? ACC_W'(-acc_im_reg) : ACC_W'(acc_im_reg);
    assign rnd_re = (ACC_W+1)'(abs_re) + ((ACC_W+1)'(1) << (CF - 1));
    assign rnd_im = (ACC_W+1)'(abs_im) + ((ACC_W+1)'(1) << (CF - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.mag)
        begin
            a_reg <= 64'(rnd_re >> CF);
            b_reg <= 64'(rnd_im >> CF);
        end
    end

    // sum of squares modulo 2^64 with one 32x32 multiplier
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p_reg;
    logic        mul_hi_reg;
    logic        mul_v_reg;
    logic [63:0] sumsq_reg;

    always_comb
    begin
        case (cmd.sq_sel)
            2'd0:    begin mul_x = a_reg[31:0];  mul_y = a_reg[31:0]; end
            2'd1:    begin mul_x = a_reg[63:32]; mul_y = a_reg[31:0]; end
            2'd2:    begin mul_x = b_reg[31:0];  mul_y = b_reg[31:0]; end
            default: begin mul_x = b_reg[63:32]; mul_y = b_reg[31:0]; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_v_reg <= 1'b0;
        else
            mul_v_reg <= cmd.sq_go;
    end

    // sqrt state
    logic [63:0] root_r_reg;
    logic [63:0] root_bit_reg;
    logic [63:0] root_t;

    assign root_t = root_r_reg + root_bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sq_go)
        begin
            mul_p_reg  <= 64'(mul_x) * 64'(mul_y);
            mul_hi_reg <= cmd.sq_sel[0];
        end
        if (cmd.start)
            sumsq_reg <= '0;
        else if (mul_v_reg)
            sumsq_reg <= sumsq_reg + (mul_hi_reg ? {mul_p_reg[30:0], 33'd0} : mul_p_reg);
        else if (cmd.root_go && sumsq_reg >= root_t)
            sumsq_reg <= sumsq_reg - root_t;
        if (cmd.start)
        begin
            root_r_reg   <= '0;
            root_bit_reg <= 64'd1 << 62;
        end
        else if (cmd.root_go)
        begin
            root_r_reg   <= (sumsq_reg >= root_t) ? ((root_r_reg >> 1) + root_bit_reg)
                                                  : (root_r_reg >> 1);
            root_bit_reg <= root_bit_reg >> 2;
        end
    end

    // result and running peak
    logic [wsm_pkg::AMP_W-1:0] amp_sat;
    logic [wsm_pkg::AMP_W-1:0] peak_base;
    logic [wsm_pkg::AMP_W-1:0] peak_new;
    logic [wsm_pkg::AMP_W-1:0] peak_reg;
    logic [FIDX_W_L-1:0]       out_fidx_reg;
    logic [wsm_pkg::AMP_W-1:0] out_amp_reg;
    logic [wsm_pkg::AMP_W-1:0] out_peak_reg;

    assign amp_sat   = (root_r_reg > 64'(wsm_pkg::AMP_MAX)) ? wsm_pkg::AMP_MAX
                                                            : root_r_reg[wsm_pkg::AMP_W-1:0];
    assign peak_base = first_reg ? '0 : peak_reg;
    assign peak_new  = (amp_sat > peak_base) ? amp_sat : peak_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            peak_reg <= '0;
        else if (cmd.finish)
            peak_reg <= peak_new;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_fidx_reg <= fidx_reg;
            out_amp_reg  <= amp_sat;
            out_peak_reg <= peak_new;
        end
    end

    assign freq_index_out = out_fidx_reg;
    assign amplitude      = out_amp_reg;
    assign peak_amplitude = out_peak_reg;

endmodule

>>> design/window_spectrum_magnitude.sv
// Window spectrum magnitude. Each accepted frequency index is evaluated as the magnitude of
// the DTFT of a rectangular or Hann window times a linear fade-in ramp, returned as unsigned
// Q12.16 (saturated) with the running peak since the last sweep start. An item runs its
// L = min(window_length, MAX_WINDOW) window points through the trig table pipeline, one per
// cycle, then squaring on a single 32x32 multiplier and a 32-step square root.
// One item is in work at a time; a finished result waits in the output register while the
// next item is taken. After reset the sine tables are filled with 2^TRIG_TABLE_BITS + 1
// entries (1025 by default) before the first item is accepted.
module window_spectrum_magnitude #(
    parameter int MAX_WINDOW      = wsm_pkg::DEF_MAX_WINDOW,
    parameter int TRIG_TABLE_BITS = wsm_pkg::DEF_TRIG_TABLE_BITS,
    parameter int COEF_FRAC_BITS  = wsm_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [wsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wsm_pkg::CFG_W-1:0]     cfg_data,
    wsm_in_if.sink                        in_ch,
    wsm_out_if.source                     out_ch
);

    wsm_pkg::cmd_t    cmd;
    wsm_pkg::status_t status;

    wsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .cmd       (cmd),
        .status    (status)
    );

    wsm_datapath #(
        .MAX_WINDOW      (MAX_WINDOW),
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .status         (status),
        .in_freq_index  (in_ch.freq_index),
        .in_first       (in_ch.first_of_sweep),
        .freq_index_out (out_ch.freq_index_out),
        .amplitude      (out_ch.amplitude),
        .peak_amplitude (out_ch.peak_amplitude)
    );

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.peak_amplitude >= out_ch.amplitude)
        else $error("peak below amplitude");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !status.pipe_busy)
        else $error("ready while point pipeline busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("ready right after input transfer");
`endif

endmodule

>>> tb/window_spectrum_magnitude_checker.sv
`timescale 1ns / 100ps
// checker for the window spectrum block: tracks register writes, predicts each result
// depends on wsm_pkg, wsm_in_if and wsm_out_if
module window_spectrum_magnitude_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [wsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wsm_pkg::CFG_W-1:0]     cfg_data,
    wsm_in_if                             in_mon,
    wsm_out_if                            out_mon,
    output int                            waiting,
    output int                            failures
);
    import wsm_pkg::*;

    localparam int QBITS   = DEF_TRIG_TABLE_BITS;
    localparam int QN      = 1 << QBITS;
    localparam int MAXWIN  = DEF_MAX_WINDOW;
    localparam int CFRAC   = DEF_COEF_FRAC_BITS;

    typedef struct packed {
        logic [FIDX_W-1:0] fidx;
        logic [AMP_W-1:0]  amp;
        logic [AMP_W-1:0]  peak;
    } spectrum_point_t;

    logic [TRIG_W-1:0] quarter_sine [0:QN];
    logic              win_hann;
    logic [12:0]       win_len;
    logic [31:0]       hann_step;
    logic [12:0]       ramp_first;
    logic [12:0]       ramp_span;
    logic [16:0]       ramp_slope;
    logic [31:0]       freq_step;
    logic [AMP_W-1:0]  peak_so_far;
    spectrum_point_t   expected_points[$];

    function automatic logic [TRIG_W-1:0] taylor_sine(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        longint      acc;
        x   = (64'(k) * 64'd1686629713) >> QBITS;
        x2  = (x * x) >> 30;
        t   = x;
        acc = longint'(x);
        for (int i = 1; i <= 8; i++)
        begin
            t = ((t * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
            if (i % 2 == 1)
                acc -= longint'(t);
            else
                acc += longint'(t);
        end
        if (acc < 0)
            acc = 0;
        acc = (acc + 8192) >>> 14;
        if (acc > 65536)
            acc = 65536;
        return TRIG_W'(acc);
    endfunction

    function automatic longint sine_q16(input logic [31:0] ph);
        logic [31:0] r;
        logic [31:0] k;
        logic [1:0]  quad;
        int          idx;
        int          m;
        r    = ph + (32'd1 << (29 - QBITS));
        k    = r >> (30 - QBITS);
        quad = k[QBITS+1:QBITS];
        idx  = int'(k) & (QN - 1);
        m    = quad[0] ? QN - idx : idx;
        return quad[1] ? -longint'(quarter_sine[m]) : longint'(quarter_sine[m]);
    endfunction

    function automatic logic [63:0] round_q16(input longint s);
        logic [63:0] a;
        a = (s < 0) ? 64'(-s) : 64'(s);
        return (a + (64'd1 << (CFRAC - 1))) >> CFRAC;
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [AMP_W-1:0] window_dtft_magnitude(input logic [FIDX_W-1:0] f);
        logic [31:0] fstep;
        logic [31:0] fph;
        logic [31:0] hph;
        int unsigned points;
        longint      re;
        longint      im;
        logic [63:0] w16;
        logic [63:0] ramp;
        logic [63:0] coef;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] mag;
        fstep  = 32'(f) * freq_step;
        fph    = 0;
        hph    = 0;
        re     = 0;
        im     = 0;
        points = (win_len > MAXWIN) ? MAXWIN : win_len;
        for (int unsigned n = 0; n < points; n++)
        begin
            if (win_hann)
                w16 = 64'(65536 - sine_q16(hph + 32'h4000_0000)) >> 1;
            else
                w16 = 65536;
            w16 = (w16 << CFRAC) >> 16;
            if (n < ramp_first)
                ramp = 0;
            else if (n >= 32'(ramp_first) + 32'(ramp_span))
                ramp = 65536;
            else
            begin
                ramp = 64'(n - ramp_first) * 64'(ramp_slope);
                if (ramp > 65536)
                    ramp = 65536;
            end
            coef = (w16 * ramp) >> 16;
            re  += longint'(coef) * sine_q16(fph + 32'h4000_0000);
            im  += longint'(coef) * sine_q16(fph);
            fph  = fph + fstep;
            hph  = hph + hann_step;
        end
        a   = round_q16(re);
        b   = round_q16(im);
        mag = floor_root(a * a + b * b);
        return (mag > 64'(AMP_MAX)) ? AMP_MAX : mag[AMP_W-1:0];
    endfunction

    initial
    begin
        for (int k = 0; k <= QN; k++)
            quarter_sine[k] = taylor_sine(k);
    end

    assign waiting = expected_points.size();

    always @(posedge clk or negedge rst_n)
    begin
        spectrum_point_t p;
        spectrum_point_t got;
        if (!rst_n)
        begin
            win_hann    <= 1'b1;
            win_len     <= 13'd1024;
            hann_step   <= 32'd4194304;
            ramp_first  <= '0;
            ramp_span   <= '0;
            ramp_slope  <= '0;
            freq_step   <= 32'd1048576;
            peak_so_far <= '0;
            failures    <= 0;
            expected_points.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW_TYPE:     win_hann   <= cfg_data[0];
                    CFG_WINDOW_LENGTH:   win_len    <= cfg_data[12:0];
                    CFG_HANN_PHASE_STEP: hann_step  <= cfg_data;
                    CFG_RAMP_START:      ramp_first <= cfg_data[12:0];
                    CFG_RAMP_LENGTH:     ramp_span  <= cfg_data[12:0];
                    CFG_RAMP_RECIP:      ramp_slope <= cfg_data[16:0];
                    CFG_FREQ_PHASE_STEP: freq_step  <= cfg_data;
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
            begin
                p.fidx = in_mon.freq_index;
                p.amp  = window_dtft_magnitude(in_mon.freq_index);
                p.peak = in_mon.first_of_sweep ? '0 : peak_so_far;
                if (p.amp > p.peak)
                    p.peak = p.amp;
                peak_so_far <= p.peak;
                expected_points.insert(expected_points.size(), p);
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got.fidx = out_mon.freq_index_out;
                got.amp  = out_mon.amplitude;
                got.peak = out_mon.peak_amplitude;
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result transfer, freq_index_out %0d", got.fidx);
                    failures <= failures + 1;
                end
                else
                begin
                    p = expected_points.pop_front();
                    if (got != p)
                        failures <= failures + 1;
                    if (got.fidx != p.fidx)
                        $error("freq_index_out expected %0d actual %0d", p.fidx, got.fidx);
                    if (got.amp != p.amp)
                        $error("amplitude expected %0d actual %0d", p.amp, got.amp);
                    if (got.peak != p.peak)
                        $error("peak_amplitude expected %0d actual %0d", p.peak, got.peak);
                end
            end
        end
    end
endmodule

>>> tb/window_spectrum_magnitude_tb.sv
`timescale 1ns / 100ps
// top of the window spectrum testbench: clock, reset, register settings and frequency stimulus
// depends on wsm_pkg, the channel interfaces, the checker and window_spectrum_magnitude
module window_spectrum_magnitude_tb;
    import wsm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   waiting;
    int                   failures;
    int                   tx_idle;
    int                   rx_idle;
    int                   sent;

    wsm_in_if  in_ch ();
    wsm_out_if out_ch ();

    window_spectrum_magnitude dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    window_spectrum_magnitude_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .waiting   (waiting),
        .failures  (failures)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle);

    task automatic drain();
        wait (waiting == 0);
        repeat (60) @(negedge clk);
    endtask

    task automatic program_window(input logic hann, input int len, input logic [31:0] hstep,
                                  input int rstart, input int rlen, input int recip,
                                  input logic [31:0] fstep);
        logic [CFG_W-1:0] vals [7];
        vals = '{32'(hann), 32'(len), hstep, 32'(rstart), 32'(rlen), 32'(recip), fstep};
        for (int i = 0; i < 7; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_point(input logic [FIDX_W-1:0] f, input logic first);
        tx_idle = (sent < 50) ? 26 : (sent < 100) ? 75 : 0;
        rx_idle = (sent < 50) ? 75 : (sent < 100) ? 26 : 0;
        while ($urandom_range(0, 99) < tx_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.freq_index     <= f;
        in_ch.first_of_sweep <= first;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic pause_sender();
        in_ch.valid <= 1'b0;
        drain();
    endtask

    task automatic random_phase(input int count);
        int len;
        int rl;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 300) : $urandom_range(1, 64);
        rl  = $urandom_range(0, len);
        program_window($urandom_range(0, 1), len,
                       $urandom_range(0, 1) ? $urandom() : 32'((64'd1 << 32) / len),
                       $urandom_range(0, len), rl,
                       ($urandom_range(0, 1) && rl != 0) ? 65536 / rl
                                                         : $urandom_range(0, 131071),
                       $urandom());
        for (int i = 0; i < count; i++)
            send_point(16'($urandom()), ($urandom_range(0, 4) == 0));
        pause_sender();
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.freq_index     = '0;
        in_ch.first_of_sweep = 1'b0;
        out_ch.ready         = 1'b0;
        tx_idle              = 26;
        rx_idle              = 75;
        sent                 = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: hann over 1024 points
        send_point(16'd0, 1'b1);
        send_point(16'hFFFF, 1'b0);
        send_point(16'd1, 1'b0);
        send_point(16'd4, 1'b1);
        pause_sender();

        // out of range index must be ignored
        cfg_we    <= 1'b1;
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 32'hFFFF_FFFF;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);

        // zero length window
        program_window(1'b0, 0, 32'd0, 0, 0, 0, 32'hFFFF_FFFF);
        send_point(16'd0, 1'b1);
        send_point(16'h5A5A, 1'b0);
        pause_sender();

        // length above the maximum, flat phase: saturated magnitude
        program_window(1'b0, 8191, 32'hFFFF_FFFF, 0, 0, 131071, 32'd0);
        send_point(16'd0, 1'b1);
        pause_sender();

        // full hann window, matching phase step
        program_window(1'b1, 4096, 32'd1048576, 0, 0, 0, 32'd1048576);
        send_point(16'd1, 1'b1);
        send_point(16'd2048, 1'b0);
        pause_sender();

        // ramp cases: consistent, steep slope, ramp start past the window
        program_window(1'b1, 64, 32'd67108864, 10, 20, 3277, 32'd67108864);
        send_point(16'd0, 1'b1);
        send_point(16'd3, 1'b0);
        pause_sender();
        program_window(1'b0, 64, 32'd0, 4, 4096, 131071, 32'h8000_0000);
        send_point(16'd1, 1'b1);
        send_point(16'd2, 1'b0);
        pause_sender();
        program_window(1'b1, 64, 32'hFFFF_FFFF, 4096, 8191, 65536, 32'd12345);
        send_point(16'd7, 1'b1);
        pause_sender();
        program_window(1'b0, 1, 32'd0, 0, 1, 65536, 32'hFFFF_FFFF);
        send_point(16'hFFFF, 1'b1);
        send_point(16'h8000, 1'b0);
        pause_sender();

        while (sent < 130)
            random_phase($urandom_range(6, 14));

        drain();
        repeat (100) @(negedge clk);
        if (failures == 0)
            $display("PASS window_spectrum_magnitude");
        else
            $display("FAIL window_spectrum_magnitude");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("FAIL window_spectrum_magnitude");
        $finish;
    end
endmodule

>>> filelist.f
design/wsm_pkg.sv
design/wsm_in_if.sv
design/wsm_out_if.sv
design/wsm_ram.sv
design/wsm_ctrl.sv
design/wsm_datapath.sv
design/window_spectrum_magnitude.sv
tb/window_spectrum_magnitude_checker.sv
tb/window_spectrum_magnitude_tb.sv
